// ===== hdl/sahbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sahbt_pkg: shared constants for the hot bucket table
// Operation codes, address widths and the hash multiplier.
// ----------------------------------------------------------------------------
package sahbt_pkg;

  localparam int unsigned AddrW = 29;
  localparam int unsigned HighW = 30;
  localparam int unsigned CntW  = 32;

  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_CODE_LOW  = 1'b0,
    CFG_CODE_HIGH = 1'b1
  } cfg_idx_e;

endpackage

// ===== hdl/sahbt_mem.sv =====
// ----------------------------------------------------------------------------
// sahbt_mem: bucket table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sahbt_mem #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 61
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sahbt_hash.sv =====
// ----------------------------------------------------------------------------
// sahbt_hash: multiplicative slot hash
// Registered product of key and multiplier; slot is its top bits.
// ----------------------------------------------------------------------------
module sahbt_hash #(
  parameter int unsigned TB = 12
) (
  input  logic                        clk_i,
  input  logic [sahbt_pkg::AddrW-1:0] key_i,
  output logic [TB-1:0]               slot_o
);

  logic [31:0] prod_q;
  logic [31:0] prod_low;

  // only the low 32 bits of the product feed the slot
  assign prod_low = {3'd0, key_i} * sahbt_pkg::HashMult;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_low;
  end

  assign slot_o = prod_q[31 -: TB];

endmodule

// ===== hdl/sampled_address_hot_bucket_table_core.sv =====
// ----------------------------------------------------------------------------
// sampled_address_hot_bucket_table_core: sampled PC hot bucket counter
// A sample outside the code range is hashed and probed, one table read per probe,
// before the next accept; a sample inside it returns to idle without hashing.
// A report scans the whole table once per ranked entry plus one final scan unless
// REPORT_ENTRIES entries are already ranked: at most REPORT_ENTRIES scans.
// Clear sweeps the table at one slot per cycle.
// Reset runs the same sweep; no item is accepted until it finishes.
// ----------------------------------------------------------------------------
module sampled_address_hot_bucket_table_core #(
  parameter int unsigned TABLE_BITS     = 12,
  parameter int unsigned PROBE_LIMIT    = 8,
  parameter int unsigned BUCKET_BYTES   = 128,  // power of two
  parameter int unsigned REPORT_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] sample_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [28:0] bucket_address_o,
  output logic [31:0] bucket_hits_o,
  output logic [31:0] total_samples_o,
  output logic [31:0] emitted_samples_o,
  output logic [31:0] lost_samples_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [29:0] cfg_data_i
);

  localparam int unsigned AW   = sahbt_pkg::AddrW;
  localparam int unsigned CW   = sahbt_pkg::CntW;
  localparam int unsigned DW   = AW + CW;
  localparam int unsigned PCW  = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned RCW  = $clog2(REPORT_ENTRIES + 1);
  localparam logic [AW-1:0] BMask = AW'(BUCKET_BYTES - 1);
  localparam logic [AW-1:0] BSize = AW'(BUCKET_BYTES);

  typedef enum logic [9:0] {
    ST_CLR    = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_SAMP   = 10'b0000000100,
    ST_HASH   = 10'b0000001000,
    ST_PSET   = 10'b0000010000,
    ST_PWAIT  = 10'b0000100000,
    ST_PCHK   = 10'b0001000000,
    ST_RSTART = 10'b0010000000,
    ST_RSCAN  = 10'b0100000000,
    ST_REMIT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]         code_low_q;
  logic [sahbt_pkg::HighW-1:0] code_high_q;
  logic [CW-1:0]         total_q, emitted_q, lost_q;
  logic [AW-1:0]         pc_q, key_q;
  logic [TABLE_BITS-1:0] slot_q, clr_idx_q;
  logic [PCW-1:0]        pcnt_q;
  logic [TABLE_BITS:0]   scan_idx_q;
  logic                  issue_q;
  logic                  have_prev_q, found_q;
  logic [AW-1:0]         prev_key_q, best_key_q;
  logic [CW-1:0]         prev_hits_q, best_hits_q;
  logic [RCW-1:0]        rcnt_q;

  logic                  out_valid_q;
  logic                  kind_q, last_q;
  logic [AW-1:0]         oaddr_q;
  logic [CW-1:0]         ohits_q, ototal_q, oemit_q, olost_q;

  // memory port
  logic                  mem_we;
  logic [TABLE_BITS-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]         mem_wdata, mem_rdata;
  logic [AW-1:0]         rkey;
  logic [CW-1:0]         rhits;
  logic [TABLE_BITS-1:0] hash_slot;

  logic in_acc, out_free, in_range, take, skip;
  logic [AW-1:0] key_raw;

  sahbt_mem #(.AW(TABLE_BITS), .DW(DW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  sahbt_hash #(.TB(TABLE_BITS)) u_hash (
    .clk_i (clk_i),
    .key_i (key_q),
    .slot_o(hash_slot)
  );

  assign rkey  = mem_rdata[DW-1:CW];
  assign rhits = mem_rdata[CW-1:0];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_range = (pc_q >= code_low_q) && ({1'b0, pc_q} < code_high_q);
  assign key_raw  = ((pc_q & ~BMask) == '0) ? BSize : (pc_q & ~BMask);

  assign mem_raddr = (state_q == ST_RSCAN) ? scan_idx_q[TABLE_BITS-1:0] : slot_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '0;
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
    end else if (state_q == ST_PCHK) begin
      if (rkey == key_q) begin
        mem_we    = 1'b1;
        mem_wdata = {rkey, rhits + CW'(1)};
      end else if (rkey == '0) begin
        mem_we    = 1'b1;
        mem_wdata = {key_q, CW'(1)};
      end
    end
  end

  // ranking compare on the entry just read
  assign skip = (rkey == '0) ||
                (have_prev_q && ((rhits > prev_hits_q) ||
                                 ((rhits == prev_hits_q) && (rkey >= prev_key_q))));
  assign take = !skip && (!found_q || (rhits > best_hits_q) ||
                          ((rhits == best_hits_q) && (rkey > best_key_q)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR: begin
        if (clr_idx_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (operation_i)
            sahbt_pkg::OP_CLEAR:  state_d = ST_CLR;
            sahbt_pkg::OP_SAMPLE: state_d = ST_SAMP;
            sahbt_pkg::OP_REPORT: state_d = ST_RSTART;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_SAMP:   state_d = in_range ? ST_IDLE : ST_HASH;
      ST_HASH:   state_d = ST_PSET;
      ST_PSET:   state_d = ST_PWAIT;
      ST_PWAIT:  state_d = ST_PCHK;
      ST_PCHK: begin
        if ((rkey == key_q) || (rkey == '0) || (pcnt_q == PCW'(PROBE_LIMIT - 1))) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PWAIT;
        end
      end
      ST_RSTART: state_d = (rcnt_q == RCW'(REPORT_ENTRIES)) ? ST_REMIT : ST_RSCAN;
      ST_RSCAN: begin
        if (scan_idx_q[TABLE_BITS] && !issue_q) state_d = ST_REMIT;
      end
      ST_REMIT: begin
        if (out_free) state_d = found_q ? ST_RSTART : ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_idx_q   <= '0;
      code_low_q  <= '0;
      code_high_q <= '0;
      total_q     <= '0;
      emitted_q   <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
      issue_q     <= 1'b0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      rcnt_q      <= '0;
      scan_idx_q  <= '0;
      pcnt_q      <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          sahbt_pkg::CFG_CODE_LOW:  code_low_q  <= cfg_data_i[AW-1:0];
          sahbt_pkg::CFG_CODE_HIGH: code_high_q <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == ST_REMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLR: clr_idx_q <= clr_idx_q + TABLE_BITS'(1);
        ST_IDLE: begin
          if (in_acc && (operation_i == sahbt_pkg::OP_CLEAR)) begin
            clr_idx_q <= '0;
            total_q   <= '0;
            emitted_q <= '0;
            lost_q    <= '0;
          end
          if (in_acc && (operation_i == sahbt_pkg::OP_REPORT)) begin
            have_prev_q <= 1'b0;
            rcnt_q      <= '0;
          end
        end
        ST_SAMP: begin
          total_q <= total_q + CW'(1);
          if (in_range) emitted_q <= emitted_q + CW'(1);
        end
        ST_PSET: pcnt_q <= '0;
        ST_PCHK: begin
          if ((rkey != key_q) && (rkey != '0)) begin
            pcnt_q <= pcnt_q + PCW'(1);
            if (pcnt_q == PCW'(PROBE_LIMIT - 1)) lost_q <= lost_q + CW'(1);
          end
        end
        ST_RSTART: begin
          scan_idx_q <= '0;
          issue_q    <= 1'b0;
          found_q    <= 1'b0;
        end
        ST_RSCAN: begin
          if (!scan_idx_q[TABLE_BITS]) begin
            scan_idx_q <= scan_idx_q + (TABLE_BITS + 1)'(1);
            issue_q    <= 1'b1;
          end else begin
            issue_q <= 1'b0;
          end
          if (issue_q && take) found_q <= 1'b1;
        end
        ST_REMIT: begin
          if (out_free && found_q) begin
            have_prev_q <= 1'b1;
            rcnt_q      <= rcnt_q + RCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_acc) begin
      pc_q <= sample_address_i[AW-1:0];
    end
    if (state_q == ST_SAMP) key_q <= key_raw;
    if (state_q == ST_PSET) slot_q <= hash_slot;
    if ((state_q == ST_PCHK) && (rkey != key_q) && (rkey != '0)) begin
      slot_q <= slot_q + TABLE_BITS'(1);
    end
    if ((state_q == ST_RSCAN) && issue_q && take) begin
      best_key_q  <= rkey;
      best_hits_q <= rhits;
    end
    if ((state_q == ST_REMIT) && out_free) begin
      kind_q   <= have_prev_q;
      oaddr_q  <= have_prev_q ? prev_key_q : '0;
      ohits_q  <= have_prev_q ? prev_hits_q : '0;
      ototal_q <= total_q;
      oemit_q  <= emitted_q;
      olost_q  <= lost_q;
      last_q   <= !found_q;
      if (found_q) begin
        prev_key_q  <= best_key_q;
        prev_hits_q <= best_hits_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign bucket_address_o  = oaddr_q;
  assign bucket_hits_o     = ohits_q;
  assign total_samples_o   = ototal_q;
  assign emitted_samples_o = oemit_q;
  assign lost_samples_o    = olost_q;
  assign last_o            = last_q;

endmodule

// ===== hdl/sahbt_checker.sv =====
// ----------------------------------------------------------------------------
// sahbt_checker: port-level checks for the hot bucket table
// Watches the output channel and reset behavior.
// ----------------------------------------------------------------------------
module sahbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [28:0] bucket_address_o,
  input logic [31:0] bucket_hits_o,
  input logic        last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(last_o) && $stable(kind_o))
    else $error("stalled output item changed");

  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> (bucket_address_o == '0) && (bucket_hits_o == '0))
    else $error("summary item carries bucket data");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> (bucket_address_o != '0))
    else $error("entry item with empty bucket address");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind sampled_address_hot_bucket_table_core sahbt_checker u_sahbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .bucket_address_o(bucket_address_o),
  .bucket_hits_o   (bucket_hits_o),
  .last_o          (last_o)
);
